// File: design/vtp_pkg.sv
`timescale 1ns / 1ps
package vtp_pkg;

  localparam int MATRIX_WORDS = 12;
  localparam int FRAC_BITS    = 16;
  localparam int Q_BITS       = 31;
  localparam logic [Q_BITS-1:0] Q_MAX = '1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PROJ_DIST    = 3'd0;
  localparam logic [2:0] CFG_NEAR_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_ASPECT_RATIO = 3'd2;
  localparam logic [2:0] CFG_HALF_WIDTH   = 3'd3;
  localparam logic [2:0] CFG_HALF_HEIGHT  = 3'd4;

  // Item kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [3:0]        slot;
    logic signed [31:0] matrix_word;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic              final_vertex;
  } vtp_in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [31:0] depth;
    logic              near_flag;
    logic              side_flag;
    logic              final_out;
  } vtp_out_t;

  typedef struct packed {
    logic [30:0] proj_dist;
    logic [30:0] near_limit;
    logic [30:0] aspect_ratio;
    logic [14:0] half_width;
    logic [14:0] half_height;
  } vtp_cfg_t;

  // A transformed vertex travelling down the pipeline.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic              near_flag;
    logic              final_vertex;
  } vtp_vert_t;

endpackage

// File: design/vertex_transform_project_top.sv
`timescale 1ns / 1ps
// Perspective vertex transform and projection.
// Input beats carry either a matrix word (kind 0, written at once into the
// twelve-word 3x4 matrix, producing no result) or a vertex (kind 1), which
// yields exactly one result beat with screen coordinates, clamped depth and
// the near, side and final flags. Beats are accepted when in_valid is high
// and in_stall is low; results leave when out_valid is high and out_stall
// is low. Registers are written through the cfg_ port, which is always
// ready, and should only be changed while no vertex is in flight.
// A vertex beat enters every cycle while in_stall is low. It passes through
// the matrix products, sums, translation add and near clamp, then the divider
// that forms the perspective factor (a setup stage, then one quotient bit per
// stage), and then the screen multiplies ending in the output register.
// The whole pipeline advances together; while a result waits under
// out_stall every stage holds and in_stall is raised, so no beat is lost
// or repeated. Reset empties the pipeline and restores the register
// defaults; matrix words hold no value until loaded.
module vertex_transform_project_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vtp_pkg::vtp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vtp_pkg::vtp_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import vtp_pkg::*;

  vtp_cfg_t  cfg_r;
  logic      en;
  logic      xf_vld, dv_vld;
  vtp_vert_t xf_vert, dv_vert;
  logic [30:0] quot;

  // Every stage moves on unless the output register holds a stalled beat.
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.proj_dist    <= 31'd12582912;
      cfg_r.near_limit   <= 31'd65536;
      cfg_r.aspect_ratio <= 31'd65536;
      cfg_r.half_width   <= 15'd160;
      cfg_r.half_height  <= 15'd112;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PROJ_DIST:    cfg_r.proj_dist    <= cfg_wdata[30:0];
        CFG_NEAR_LIMIT:   cfg_r.near_limit   <= cfg_wdata[30:0];
        CFG_ASPECT_RATIO: cfg_r.aspect_ratio <= cfg_wdata[30:0];
        CFG_HALF_WIDTH:   cfg_r.half_width   <= cfg_wdata[14:0];
        CFG_HALF_HEIGHT:  cfg_r.half_height  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  vtp_xform u_xform (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .near_limit (cfg_r.near_limit),
    .vld        (xf_vld),
    .vert       (xf_vert)
  );

  vtp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (xf_vld),
    .in_vert   (xf_vert),
    .proj_dist (cfg_r.proj_dist),
    .out_vld   (dv_vld),
    .out_vert  (dv_vert),
    .quot      (quot)
  );

  vtp_proj u_proj (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_vld       (dv_vld),
    .in_vert      (dv_vert),
    .quot         (quot),
    .aspect_ratio (cfg_r.aspect_ratio),
    .half_width   (cfg_r.half_width),
    .half_height  (cfg_r.half_height),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

`ifndef NO_ASSERTIONS
  // Input is held off only when a finished beat is stuck at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output beat");

  // Reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // A clamped vertex reports the near plane as its depth.
  a_near_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.near_flag) |-> (out_data.depth == {1'b0, cfg_r.near_limit}))
    else $error("near flag set but depth is not the near limit");
`endif

endmodule

// File: design/vtp_xform.sv
`timescale 1ns / 1ps
module vtp_xform (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  vtp_pkg::vtp_in_t  in_data,
  input  logic [30:0]       near_limit,
  output logic              vld,
  output vtp_pkg::vtp_vert_t vert
);
  import vtp_pkg::*;

  logic [31:0]        mat_r [MATRIX_WORDS];
  logic signed [63:0] prod_r [9];
  logic [31:0]        tr1_r [3];
  logic [31:0]        tr2_r [3];
  logic [47:0]        acc_r [3];
  logic signed [31:0] xyz_r [3];
  logic [3:0]         v_r;
  logic [2:0]         fin_r;
  logic signed [31:0] crd [3];
  logic               load_we;
  vtp_vert_t          vert_r;

  assign crd[0] = in_data.vx;
  assign crd[1] = in_data.vy;
  assign crd[2] = in_data.vz;
  assign load_we = en && in_valid && (in_data.kind == KIND_LOAD)
                   && (in_data.slot < 4'(MATRIX_WORDS));

  always_ff @(posedge clk) begin
    if (load_we) begin
      mat_r[in_data.slot] <= in_data.matrix_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid && (in_data.kind == KIND_VERTEX)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          prod_r[r*3+i] <= $signed(mat_r[r*4+i]) * crd[i];
        end
        tr1_r[r] <= mat_r[r*4+3];
        tr2_r[r] <= tr1_r[r];
        acc_r[r] <= prod_r[r*3][47:0] + prod_r[r*3+1][47:0] + prod_r[r*3+2][47:0];
        xyz_r[r] <= $signed(acc_r[r][47:16] + tr2_r[r]);
      end
      fin_r <= {fin_r[1:0], in_data.final_vertex};
      vert_r.x <= xyz_r[0];
      vert_r.y <= xyz_r[1];
      if (xyz_r[2] < $signed({1'b0, near_limit})) begin
        vert_r.z         <= $signed({1'b0, near_limit});
        vert_r.near_flag <= 1'b1;
      end else begin
        vert_r.z         <= xyz_r[2];
        vert_r.near_flag <= 1'b0;
      end
      vert_r.final_vertex <= fin_r[2];
    end
  end

  assign vld  = v_r[3];
  assign vert = vert_r;

endmodule

// File: design/vtp_div.sv
`timescale 1ns / 1ps
module vtp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  vtp_pkg::vtp_vert_t in_vert,
  input  logic [30:0]        proj_dist,
  output logic               out_vld,
  output vtp_pkg::vtp_vert_t out_vert,
  output logic [30:0]        quot
);
  import vtp_pkg::*;

  // Stage 0 sets up the remainder and the overflow test; each further stage
  // retires one quotient bit.
  logic [30:0] rem_r  [Q_BITS+1];
  logic [30:0] dl_r   [Q_BITS+1];
  logic [30:0] q_r    [Q_BITS+1];
  logic        sat_r  [Q_BITS+1];
  vtp_vert_t   vert_r [Q_BITS+1];
  logic [Q_BITS:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_BITS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {15'd0, proj_dist[30:15]};
      dl_r[0]   <= {proj_dist[14:0], 16'd0};
      q_r[0]    <= '0;
      sat_r[0]  <= {15'd0, proj_dist} >= {in_vert.z[30:0], 15'd0};
      vert_r[0] <= in_vert;
    end
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    logic [31:0] t_nxt;
    logic [31:0] d_nxt;
    logic        ge_nxt;

    assign t_nxt  = {rem_r[k], dl_r[k][30]};
    assign ge_nxt = t_nxt >= {1'b0, vert_r[k].z[30:0]};
    assign d_nxt  = t_nxt - {1'b0, vert_r[k].z[30:0]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge_nxt ? d_nxt[30:0] : t_nxt[30:0];
        dl_r[k+1]   <= {dl_r[k][29:0], 1'b0};
        q_r[k+1]    <= {q_r[k][29:0], ge_nxt};
        sat_r[k+1]  <= sat_r[k];
        vert_r[k+1] <= vert_r[k];
      end
    end
  end

  assign out_vld  = v_r[Q_BITS];
  assign out_vert = vert_r[Q_BITS];
  assign quot     = sat_r[Q_BITS] ? Q_MAX : q_r[Q_BITS];

endmodule

// File: design/vtp_proj.sv
`timescale 1ns / 1ps
module vtp_proj (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  vtp_pkg::vtp_vert_t in_vert,
  input  logic [30:0]        quot,
  input  logic [30:0]        aspect_ratio,
  input  logic [14:0]        half_width,
  input  logic [14:0]        half_height,
  output logic               out_valid,
  output vtp_pkg::vtp_out_t  out_data
);
  import vtp_pkg::*;

  logic signed [63:0] px_r;
  logic [61:0]        pa_r;
  logic signed [63:0] py_r;
  logic signed [31:0] y1_r;
  logic signed [15:0] sx2_r;
  vtp_vert_t          v1_r;
  vtp_vert_t          v2_r;
  logic [2:0]         v_r;
  vtp_out_t           out_r;
  logic signed [15:0] sy_nxt;
  logic signed [16:0] hw_s, hh_s, sx_s, sy_s;
  logic               side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_vld};
    end
  end

  assign sy_nxt = py_r[47:32];
  assign hw_s   = $signed({2'b00, half_width});
  assign hh_s   = $signed({2'b00, half_height});
  assign sx_s   = $signed({sx2_r[15], sx2_r});
  assign sy_s   = $signed({sy_nxt[15], sy_nxt});
  assign side_nxt = (sx_s < -hw_s) || (sx_s > hw_s) || (sy_s < -hh_s) || (sy_s > hh_s);

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= in_vert.x * $signed({1'b0, quot});
      pa_r  <= aspect_ratio * quot;
      y1_r  <= in_vert.y;
      v1_r  <= in_vert;
      py_r  <= y1_r * $signed(pa_r[47:16]);
      sx2_r <= px_r[47:32];
      v2_r  <= v1_r;
      out_r.screen_x  <= sx2_r;
      out_r.screen_y  <= sy_nxt;
      out_r.depth     <= v2_r.z;
      out_r.near_flag <= v2_r.near_flag;
      out_r.side_flag <= side_nxt;
      out_r.final_out <= v2_r.final_vertex;
    end
  end

  assign out_valid = v_r[2];
  assign out_data  = out_r;

endmodule
